// ===== src/b64enc_pkg.sv =====
// shared types, constants and the alphabet lookup for the base64 stream encoder
`timescale 1ns / 1ps

package b64enc_pkg;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  localparam logic [7:0] CharPad   = 8'h3D;  // '='
  localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
  localparam logic [7:0] CharSlash = 8'h2F;  // '/'
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharLoA   = 8'h61;
  localparam logic [7:0] CharZero  = 8'h30;

  localparam logic [7:0] GplReset  = 8'd19;
  localparam logic [7:0] LgdMax    = 8'hFF;

  // position of a character within one group record
  localparam logic [2:0] IdxSext0 = 3'd0;
  localparam logic [2:0] IdxSext1 = 3'd1;
  localparam logic [2:0] IdxSext2 = 3'd2;
  localparam logic [2:0] IdxSext3 = 3'd3;
  localparam logic [2:0] IdxCr    = 3'd4;
  localparam logic [2:0] IdxLf    = 3'd5;

  // number of real bytes in a group
  localparam logic [1:0] NBytes1 = 2'd1;
  localparam logic [1:0] NBytes2 = 2'd2;
  localparam logic [1:0] NBytes3 = 2'd3;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       crlf;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      b64_char = CharUpA + v8;
    end else if (v < 6'd52) begin
      b64_char = CharLoA + v8 - 8'd26;
    end else if (v < 6'd62) begin
      b64_char = CharZero + v8 - 8'd52;
    end else if (v == 6'd62) begin
      b64_char = CharPlus;
    end else begin
      b64_char = CharSlash;
    end
  endfunction

endpackage

// ===== src/base64_stream_encoder.sv =====
// a byte that closes a group is written into the group queue; the back end then loads its
// first character into the output register. throughput: one input byte per cycle while the
// group queue has room; the back end emits one character per cycle while the output is not
// stalled, and so sets the sustained intake; bytes that only fill a group take no queue entry
// reset: asynchronous active-low; clears fill, line position and queue, groups_per_line to 19
`timescale 1ns / 1ps

module base64_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast,   // run_end
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i      // groups_per_line
);

  b64enc_pkg::group_t     push_data;
  b64enc_pkg::group_t     head;
  b64enc_pkg::fifo_stat_t fifo_stat;
  logic                   push;
  logic                   pop;

  b64enc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fifo_stat_i   (fifo_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  b64enc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (fifo_stat)
  );

  b64enc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (!fifo_stat.empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== src/b64enc_front.sv =====
// front end: gathers bytes into groups, tracks line position, holds the config register
`timescale 1ns / 1ps

module b64enc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
  input  logic                 s_axis_tlast,  // last_byte
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [7:0]           cfg_data_i,    // groups_per_line
  input  b64enc_pkg::fifo_stat_t fifo_stat_i,
  output logic                 push_o,
  output b64enc_pkg::group_t   push_data_o
);

  logic [7:0] gpl_q, gpl_d;
  logic [1:0] fill_q, fill_d;
  logic [7:0] held0_q, held0_d;
  logic [7:0] held1_q, held1_d;
  logic [7:0] lgd_q, lgd_d;
  logic [7:0] lgd_inc;
  logic       accept;
  logic       hold;
  logic       crlf;

  assign s_axis_tready = !fifo_stat_i.full;
  assign cfg_ready_o   = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign hold          = (fill_q < 2'd2) && !s_axis_tlast;

  assign lgd_inc = (lgd_q < b64enc_pkg::LgdMax) ? lgd_q + 8'd1 : lgd_q;
  assign crlf    = lgd_inc >= gpl_q;

  always_comb begin
    gpl_d   = gpl_q;
    fill_d  = fill_q;
    held0_d = held0_q;
    held1_d = held1_q;
    lgd_d   = lgd_q;
    push_o  = 1'b0;

    push_data_o.b0     = (fill_q >= 2'd1) ? held0_q : s_axis_tdata;
    push_data_o.b1     = (fill_q == 2'd2) ? held1_q :
                         ((fill_q == 2'd1) ? s_axis_tdata : 8'h00);
    push_data_o.b2     = (fill_q == 2'd2) ? s_axis_tdata : 8'h00;
    push_data_o.nbytes = fill_q + 2'd1;
    push_data_o.crlf   = crlf;

    if (cfg_valid_i) begin
      gpl_d = cfg_data_i;
    end

    if (accept) begin
      if (hold) begin
        if (fill_q == 2'd0) begin
          held0_d = s_axis_tdata;
        end else begin
          held1_d = s_axis_tdata;
        end
        fill_d = fill_q + 2'd1;
      end else begin
        push_o = 1'b1;
        fill_d = 2'd0;
        // a finished message always starts the next one on a fresh line
        lgd_d  = (crlf || s_axis_tlast) ? 8'd0 : lgd_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpl_q  <= b64enc_pkg::GplReset;
      fill_q <= 2'd0;
      lgd_q  <= 8'd0;
    end else begin
      gpl_q  <= gpl_d;
      fill_q <= fill_d;
      lgd_q  <= lgd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held0_q <= held0_d;
    held1_q <= held1_d;
  end

endmodule

// ===== src/b64enc_fifo.sv =====
// short queue of group records between the front and back ends
`timescale 1ns / 1ps

module b64enc_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  b64enc_pkg::group_t     push_data_i,
  input  logic                   pop_i,
  output b64enc_pkg::group_t     head_o,
  output b64enc_pkg::fifo_stat_t stat_o
);

  b64enc_pkg::group_t mem_q [b64enc_pkg::FifoDepth];
  logic [b64enc_pkg::FifoAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [b64enc_pkg::FifoAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [b64enc_pkg::FifoAw:0]   cnt_q, cnt_d;

  localparam logic [b64enc_pkg::FifoAw:0] Depth = (b64enc_pkg::FifoAw + 1)'(b64enc_pkg::FifoDepth);
  localparam logic [b64enc_pkg::FifoAw-1:0] LastPtr =
    b64enc_pkg::FifoAw'(b64enc_pkg::FifoDepth - 1);

  assign stat_o.full  = cnt_q == Depth;
  assign stat_o.empty = cnt_q == '0;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/b64enc_back.sv =====
// back end: turns group records into characters, one per cycle unless the output is stalled, into an output register
`timescale 1ns / 1ps

module b64enc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b64enc_pkg::group_t head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // [7:0] out_char
  output logic               m_axis_tlast   // run_end
);

  logic [2:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       load;
  logic [7:0] cur_char;
  logic       cur_last;

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = char_q;
  assign m_axis_tlast  = last_q;

  // a group record is waiting and the output slot is free or being drained this cycle
  assign load = head_valid_i && (!vld_q || m_axis_tready);

  always_comb begin
    case (idx_q)
      b64enc_pkg::IdxSext0: cur_char = b64enc_pkg::b64_char(head_i.b0[7:2]);
      b64enc_pkg::IdxSext1: cur_char = b64enc_pkg::b64_char({head_i.b0[1:0], head_i.b1[7:4]});
      b64enc_pkg::IdxSext2: cur_char = (head_i.nbytes != b64enc_pkg::NBytes1) ?
                              b64enc_pkg::b64_char({head_i.b1[3:0], head_i.b2[7:6]}) :
                              b64enc_pkg::CharPad;
      b64enc_pkg::IdxSext3: cur_char = (head_i.nbytes == b64enc_pkg::NBytes3) ?
                              b64enc_pkg::b64_char(head_i.b2[5:0]) :
                              b64enc_pkg::CharPad;
      b64enc_pkg::IdxCr:    cur_char = b64enc_pkg::CharCr;
      b64enc_pkg::IdxLf:    cur_char = b64enc_pkg::CharLf;
      default:              cur_char = b64enc_pkg::CharPad;
    endcase
  end

  assign cur_last = ((idx_q == b64enc_pkg::IdxSext3) && !head_i.crlf) ||
                    (idx_q == b64enc_pkg::IdxLf);

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    char_d = char_q;
    last_d = last_q;
    pop_o  = 1'b0;
    if (vld_q && m_axis_tready) begin
      vld_d = 1'b0;
    end
    if (load) begin
      vld_d  = 1'b1;
      char_d = cur_char;
      last_d = cur_last;
      if (cur_last) begin
        pop_o = 1'b1;
        idx_d = b64enc_pkg::IdxSext0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= b64enc_pkg::IdxSext0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule

// ===== tb/base64_stream_encoder_tb.sv =====
// self-checking testbench for the base64 stream encoder: random bursts in, random stalls out
`timescale 1ns / 1ps

module base64_stream_encoder_tb;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned LongHoldLen  = 400;
  localparam int unsigned HoldAfterBytes = 200;

  // index 0 sits in the top bits of the packed literal, so 'A' is entry 0
  localparam logic [0:63][7:0] B64Symbols =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
  } enc_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = 8'h00;

  raw_byte_t  byte_feed[$];
  enc_char_t  char_expect_q[$];

  // encoder state as the testbench predicts it
  logic [7:0] gpl_m = b64enc_pkg::GplReset;
  logic [7:0] held_m[2] = '{8'h00, 8'h00};
  logic [1:0] fill_m = 2'd0;
  logic [7:0] line_m = 8'h00;

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned bytes_accepted = 0;
  logic        byte_taken = 1'b0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;

  base64_stream_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    return B64Symbols[v];
  endfunction

  // predicts the characters that one accepted byte produces
  function automatic void encode_byte(input logic [7:0] din, input logic fin);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] chars[6];
    int         n;
    logic [1:0] have;
    have = fill_m;
    if (have < 2'd2 && !fin) begin
      held_m[have] = din;
      fill_m = have + 2'd1;
      return;
    end
    b0 = (have >= 2'd1) ? held_m[0] : din;
    b1 = (have == 2'd2) ? held_m[1] : ((have == 2'd1) ? din : 8'h00);
    b2 = (have == 2'd2) ? din : 8'h00;
    chars[0] = b64_sym(b0[7:2]);
    chars[1] = b64_sym({b0[1:0], b1[7:4]});
    chars[2] = (have >= 2'd1) ? b64_sym({b1[3:0], b2[7:6]}) : b64enc_pkg::CharPad;
    chars[3] = (have == 2'd2) ? b64_sym(b2[5:0]) : b64enc_pkg::CharPad;
    n = 4;
    if (line_m != b64enc_pkg::LgdMax) line_m = line_m + 8'd1;
    if (line_m >= gpl_m) begin
      chars[4] = b64enc_pkg::CharCr;
      chars[5] = b64enc_pkg::CharLf;
      n = 6;
      line_m = 8'h00;
    end
    fill_m = 2'd0;
    held_m[0] = 8'h00;
    held_m[1] = 8'h00;
    if (fin) line_m = 8'h00;
    for (int i = 0; i < n; i++) begin
      char_expect_q.push_back('{ch: chars[i], run_end: (i == n - 1)});
    end
  endfunction

  // byte driver: bursts of random length separated by random gaps
  always @(negedge clk_i) begin : drive_p
    raw_byte_t item;
    if (rst_ni && (!s_axis_tvalid || byte_taken)) begin
      if (gap_left > 0 || byte_feed.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        item = byte_feed.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item.data;
        s_axis_tlast  <= item.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // character sink: stall pattern changes at random intervals, plus one long hold
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_accepted >= HoldAfterBytes) begin
      m_axis_tready <= 1'b0;
      hold_left <= LongHoldLen;
      hold_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(10, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor: predict on every byte transaction, check on every character transaction
  always @(posedge clk_i) begin : check_p
    enc_char_t want;
    if (s_axis_tvalid && s_axis_tready) begin
      encode_byte(s_axis_tdata, s_axis_tlast);
      bytes_accepted = bytes_accepted + 1;
    end
    byte_taken = s_axis_tvalid && s_axis_tready;
    if (m_axis_tvalid && m_axis_tready) begin
      if (char_expect_q.size() == 0) begin
        $error("unexpected character: out_char=%h run_end=%b", m_axis_tdata, m_axis_tlast);
        err_cnt = err_cnt + 1;
      end else begin
        want = char_expect_q.pop_front();
        if (m_axis_tdata !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, m_axis_tdata);
          err_cnt = err_cnt + 1;
        end
        if (m_axis_tlast !== want.run_end) begin
          $error("run_end: expected %b, got %b", want.run_end, m_axis_tlast);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[base64_stream_encoder] ERROR");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] d, input logic fin);
    byte_feed.push_back('{data: d, last: fin});
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (byte_feed.size() != 0 || s_axis_tvalid || char_expect_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_gpl(input logic [7:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    gpl_m = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // mostly short messages, some long enough to wrap lines, a few left open
  task automatic add_messages(input int unsigned target);
    int unsigned cnt;
    int unsigned len;
    logic        closed;
    cnt = 0;
    while (cnt < target) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 24);
      closed = ($urandom_range(0, 9) != 0);
      for (int unsigned i = 0; i < len; i++) begin
        add_byte(8'($urandom_range(0, 255)), closed && (i == len - 1));
      end
      cnt = cnt + len;
    end
  endtask

  initial begin
    logic [7:0] gpl_list[8];
    gpl_list = '{8'd2, 8'd255, 8'd1, 8'd5, 8'd0, 8'd128, 8'd19, 8'd3};
    gpl_list[7] = 8'($urandom_range(1, 12));
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: single byte, two bytes, full last group, '+' and '/'
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b1);
    add_byte(8'hFB, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b1);
    wait_idle();

    // zero groups per line breaks after every group
    write_gpl(8'd0);
    for (int i = 0; i < 6; i++) add_byte(8'($urandom_range(0, 255)), i == 5);
    wait_idle();

    // lower the register mid-line: the next group ends the line
    write_gpl(8'd3);
    for (int i = 0; i < 6; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_idle();
    write_gpl(8'd1);
    for (int i = 0; i < 3; i++) add_byte(8'($urandom_range(0, 255)), i == 2);
    wait_idle();

    foreach (gpl_list[p]) begin
      write_gpl(gpl_list[p]);
      add_messages(35);
      wait_idle();
    end

    if (err_cnt == 0 && char_expect_q.size() == 0) begin
      $display("[base64_stream_encoder] OK");
    end else begin
      $display("[base64_stream_encoder] ERROR");
    end
    $finish;
  end

endmodule
